// ===== hw/rtl/rtp1b_pkg.sv =====
// Shared constants, codes and types of the one-byte extension parser.
package rtp1b_pkg;

    localparam int unsigned MAX_LEN_DEF = 2048;

    localparam logic [6:0]  FIXED_HDR        = 7'd12;
    localparam logic [15:0] ONE_BYTE_PROFILE = 16'hBEDE;
    localparam logic [3:0]  ID_STOP          = 4'hF;
    localparam logic [3:0]  ID_PAD           = 4'h0;
    localparam logic [3:0]  TARGET_ID_RESET  = 4'd1;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_SHORT     = 3'd2,
        ST_HDR_OVER  = 3'd3,
        ST_OVERLONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic        overlong;
        logic [3:0]  csrc;
        logic        ext_bit;
        logic [15:0] ext_words;
        logic        match;
        logic [31:0] word;
        logic [10:0] offset;
        logic [4:0]  dlen;
    } t_snap;

endpackage

// ===== hw/rtl/rtp1b_track.sv =====
// Per-packet header tracker and extension element walk with a packet summary register.
module rtp1b_track #(
    parameter int unsigned MAX_LEN = rtp1b_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    input  logic [3:0]                       i_target_id,
    input  logic                             i_snap_take,
    output logic                             o_snap_valid,
    output rtp1b_pkg::t_snap                 o_snap,
    output logic [$clog2(MAX_LEN+1)-1:0]     o_snap_len
);
    import rtp1b_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LEN + 1);
    localparam int unsigned NW = $clog2(MAX_LEN + 17);
    localparam int unsigned CW = ((PW > 19) ? PW : 19) + 1;

    logic [PW-1:0] r_pos, n_pos;
    logic [3:0]    r_csrc, n_csrc;
    logic          r_xbit, n_xbit;
    logic [15:0]   r_prof, n_prof;
    logic [15:0]   r_ext_words, n_ext_words;
    logic [NW-1:0] r_next, n_next;
    logic          r_stopped, n_stopped;
    logic          r_match, n_match;
    logic [31:0]   r_word, n_word;
    logic [10:0]   r_off, n_off;
    logic [4:0]    r_dlen, n_dlen;

    logic          r_snap_valid, n_snap_valid;
    t_snap         r_snap, n_snap;
    logic [PW-1:0] r_snap_len, n_snap_len;

    logic [CW-1:0] pos_c, hlen_c, ds_c, de_c, off_c;
    logic [1:0]    cap_k;
    logic          active;
    logic [3:0]    elem_id;

    assign pos_c   = CW'(r_pos);
    assign hlen_c  = CW'(FIXED_HDR) + CW'({r_csrc, 2'b00});
    assign ds_c    = hlen_c + CW'(4);
    assign de_c    = ds_c + CW'({r_ext_words, 2'b00});
    assign off_c   = CW'(r_off);
    assign cap_k   = r_pos[1:0] - r_off[1:0];
    assign active  = (r_pos < PW'(MAX_LEN));
    assign elem_id = i_data_byte[7:4];

    always_comb begin
        n_pos        = r_pos;
        n_csrc       = r_csrc;
        n_xbit       = r_xbit;
        n_prof       = r_prof;
        n_ext_words  = r_ext_words;
        n_next       = r_next;
        n_stopped    = r_stopped;
        n_match      = r_match;
        n_word       = r_word;
        n_off        = r_off;
        n_dlen       = r_dlen;
        n_snap_valid = r_snap_valid && !i_snap_take;
        n_snap       = r_snap;
        n_snap_len   = r_snap_len;

        if (i_take && active) begin
            n_pos = r_pos + PW'(1);
            if (r_pos == '0) begin
                n_csrc = i_data_byte[3:0];
                n_xbit = i_data_byte[4];
                n_next = NW'({i_data_byte[3:0], 2'b00}) + NW'(16);
            end else begin
                if (r_xbit) begin
                    if (pos_c == hlen_c || pos_c == hlen_c + CW'(1)) begin
                        n_prof = {r_prof[7:0], i_data_byte};
                    end else if (pos_c == hlen_c + CW'(2) || pos_c == hlen_c + CW'(3)) begin
                        n_ext_words = {r_ext_words[7:0], i_data_byte};
                    end
                end
                if (r_match && pos_c > off_c && pos_c <= off_c + CW'(3)) begin
                    case (cap_k)
                        2'd1:    n_word[23:16] = r_word[23:16] | i_data_byte;
                        2'd2:    n_word[15:8]  = r_word[15:8]  | i_data_byte;
                        2'd3:    n_word[7:0]   = r_word[7:0]   | i_data_byte;
                        default: n_word        = r_word;
                    endcase
                end
                if (r_xbit && r_prof == ONE_BYTE_PROFILE && !r_stopped && !r_match &&
                    CW'(r_next) == pos_c && pos_c >= ds_c && pos_c < de_c) begin
                    if (elem_id == ID_STOP) begin
                        n_stopped = 1'b1;
                    end else if (elem_id == ID_PAD) begin
                        n_next = NW'(r_pos) + NW'(1);
                    end else if (elem_id == i_target_id) begin
                        n_match = 1'b1;
                        n_word  = {i_data_byte, 24'd0};
                        n_off   = 11'(r_pos);
                        n_dlen  = {1'b0, i_data_byte[3:0]} + 5'd1;
                    end else begin
                        n_next = NW'(r_pos) + NW'(i_data_byte[3:0]) + NW'(2);
                    end
                end
            end
        end

        if (i_take && i_last_byte) begin
            n_snap_valid     = 1'b1;
            n_snap.overlong  = !active;
            n_snap.csrc      = n_csrc;
            n_snap.ext_bit   = n_xbit;
            n_snap.ext_words = n_ext_words;
            n_snap.match     = n_match;
            n_snap.word      = n_word;
            n_snap.offset    = n_off;
            n_snap.dlen      = n_dlen;
            n_snap_len       = r_pos + PW'(1);
            n_pos            = '0;
            n_csrc           = '0;
            n_xbit           = 1'b0;
            n_prof           = '0;
            n_ext_words      = '0;
            n_next           = '0;
            n_stopped        = 1'b0;
            n_match          = 1'b0;
            n_word           = '0;
            n_off            = '0;
            n_dlen           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_csrc       <= '0;
            r_xbit       <= 1'b0;
            r_prof       <= '0;
            r_ext_words  <= '0;
            r_next       <= '0;
            r_stopped    <= 1'b0;
            r_match      <= 1'b0;
            r_word       <= '0;
            r_off        <= '0;
            r_dlen       <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_csrc       <= n_csrc;
            r_xbit       <= n_xbit;
            r_prof       <= n_prof;
            r_ext_words  <= n_ext_words;
            r_next       <= n_next;
            r_stopped    <= n_stopped;
            r_match      <= n_match;
            r_word       <= n_word;
            r_off        <= n_off;
            r_dlen       <= n_dlen;
            r_snap_valid <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap     <= n_snap;
        r_snap_len <= n_snap_len;
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;
    assign o_snap_len   = r_snap_len;

endmodule

// ===== hw/rtl/rtp1b_result.sv =====
// Result formatting from a packet summary into the output register.
module rtp1b_result #(
    parameter int unsigned MAX_LEN = rtp1b_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_snap_valid,
    input  rtp1b_pkg::t_snap                 i_snap,
    input  logic [$clog2(MAX_LEN+1)-1:0]     i_snap_len,
    output logic                             o_snap_take,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [2:0]                       o_status,
    output logic                             o_has_extension,
    output logic [11:0]                      o_payload_offset,
    output logic [11:0]                      o_payload_length,
    output logic [7:0]                       o_first_data_byte,
    output logic [31:0]                      o_element_word,
    output logic [10:0]                      o_element_offset,
    output logic [4:0]                       o_element_data_length
);
    import rtp1b_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LEN + 1);
    localparam int unsigned CW = ((PW > 19) ? PW : 19) + 1;

    logic          r_valid, n_valid;
    logic          load;
    logic [CW-1:0] len_c, hlen_c, ext_end_c, poff_c;
    t_status       status;
    logic          has_ext;
    logic [11:0]   poff, plen;
    logic          found;

    logic [2:0]    r_status;
    logic          r_has_ext;
    logic [11:0]   r_poff, r_plen;
    logic [7:0]    r_first;
    logic [31:0]   r_word;
    logic [10:0]   r_off;
    logic [4:0]    r_dlen;

    assign len_c     = CW'(i_snap_len);
    assign hlen_c    = CW'(FIXED_HDR) + CW'({i_snap.csrc, 2'b00}) + CW'({i_snap.ext_bit, 2'b00});
    assign ext_end_c = hlen_c + CW'({i_snap.ext_words, 2'b00});

    always_comb begin
        status  = ST_NOT_FOUND;
        has_ext = 1'b0;
        poff    = '0;
        plen    = '0;
        poff_c  = hlen_c;
        if (i_snap.overlong) begin
            status = ST_OVERLONG;
        end else if (len_c < CW'(FIXED_HDR)) begin
            status = ST_SHORT;
        end else begin
            has_ext = i_snap.ext_bit;
            if (len_c < hlen_c) begin
                status = ST_HDR_OVER;
                poff   = hlen_c[11:0];
            end else begin
                if (i_snap.ext_bit && len_c > ext_end_c) begin
                    poff_c = ext_end_c;
                    if (i_snap.match) begin
                        status = ST_FOUND;
                    end
                end
                poff = poff_c[11:0];
                plen = 12'(len_c - poff_c);
            end
        end
    end

    assign found       = (status == ST_FOUND);
    assign load        = !r_valid || !i_stall;
    assign o_snap_take = i_snap_valid && load;
    assign n_valid     = load ? i_snap_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_status  <= status;
            r_has_ext <= has_ext;
            r_poff    <= poff;
            r_plen    <= plen;
            r_first   <= found ? i_snap.word[23:16] : 8'd0;
            r_word    <= found ? i_snap.word : 32'd0;
            r_off     <= found ? i_snap.offset : 11'd0;
            r_dlen    <= found ? i_snap.dlen : 5'd0;
        end
    end

    assign o_valid               = r_valid;
    assign o_status              = r_status;
    assign o_has_extension       = r_has_ext;
    assign o_payload_offset      = r_poff;
    assign o_payload_length      = r_plen;
    assign o_first_data_byte     = r_first;
    assign o_element_word        = r_word;
    assign o_element_offset      = r_off;
    assign o_element_data_length = r_dlen;

endmodule

// ===== hw/rtl/rtp_one_byte_extension_parser_unit.sv =====
// Top level of the one-byte RTP header extension parser.
//
// Channel   Direction  Handshake           Contents
// input     in         i_valid / o_stall   i_data_byte, i_last_byte
// result    out        o_valid / i_stall   status, payload offset and length, matched element
// config    in         i_target_id_we      i_target_id
//
// One byte is taken per cycle while o_stall is low, with no gap between packets.
// A byte passes the input register, then updates the tracker state.
// A packet's result passes the summary register, then the output register.
// Reset is synchronous and empties every stage; the target id returns to 1.
// A stalled result holds the output register while bytes keep flowing; the input
// stalls only when a final byte finds the summary register behind it full as well.
module rtp_one_byte_extension_parser_unit #(
    parameter int unsigned MAX_LEN = rtp1b_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_target_id_we,
    input  logic [3:0]  i_target_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_has_extension,
    output logic [11:0] o_payload_offset,
    output logic [11:0] o_payload_length,
    output logic [7:0]  o_first_data_byte,
    output logic [31:0] o_element_word,
    output logic [10:0] o_element_offset,
    output logic [4:0]  o_element_data_length
);
    import rtp1b_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LEN + 1);

    logic          r_s0_valid, n_s0_valid;
    logic [7:0]    r_s0_byte;
    logic          r_s0_last;
    logic [3:0]    r_target_id;
    logic          accept, s0_move, s1_ready;
    logic          snap_valid, snap_take;
    t_snap         snap;
    logic [PW-1:0] snap_len;

    assign s1_ready   = !snap_valid || snap_take;
    assign s0_move    = r_s0_valid && (!r_s0_last || s1_ready);
    assign o_stall    = r_s0_valid && !s0_move;
    assign accept     = i_valid && !o_stall;
    assign n_s0_valid = accept || (r_s0_valid && !s0_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_target_id <= TARGET_ID_RESET;
        end else begin
            r_s0_valid <= n_s0_valid;
            if (i_target_id_we) begin
                r_target_id <= i_target_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_byte <= i_data_byte;
            r_s0_last <= i_last_byte;
        end
    end

    rtp1b_track #(
        .MAX_LEN (MAX_LEN)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (s0_move),
        .i_data_byte  (r_s0_byte),
        .i_last_byte  (r_s0_last),
        .i_target_id  (r_target_id),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .o_snap_len   (snap_len)
    );

    rtp1b_result #(
        .MAX_LEN (MAX_LEN)
    ) u_result (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_snap_valid          (snap_valid),
        .i_snap                (snap),
        .i_snap_len            (snap_len),
        .o_snap_take           (snap_take),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_status              (o_status),
        .o_has_extension       (o_has_extension),
        .o_payload_offset      (o_payload_offset),
        .o_payload_length      (o_payload_length),
        .o_first_data_byte     (o_first_data_byte),
        .o_element_word        (o_element_word),
        .o_element_offset      (o_element_offset),
        .o_element_data_length (o_element_data_length)
    );

endmodule
